[rtl/core/pfx_pkg.sv]
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types, character codes and status codes for the postfix evaluator.
// ----------------------------------------------------------------------------
package pfx_pkg;

  // Default stack depth
  localparam int PFX_STACK_DEPTH = 64;

  // Field widths
  localparam int SYM_W   = 8;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 3;
  localparam int OUT_W   = 40;  // value + status, padded to whole bytes
  localparam int DIV_BITS = 32;

  // Character codes
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYM_W-1:0] CH_PCT   = 8'h25;
  localparam logic [SYM_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [VAL_W-1:0] DIGIT_BASE = 32'd48;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNDER   = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVER    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd3;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd4;

  // Symbol classes
  typedef enum logic [1:0] {
    CLS_NUL,
    CLS_PAREN,
    CLS_OP,
    CLS_OPND
  } cls_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              take;       // input beat accepted, latch symbol
    logic              push;       // push operand
    logic              rd_second;  // read entry below top of stack
    logic              alu_wr;     // write add/sub/mul result, pop one
    logic              div_start;  // launch divider
    logic              div_wr;     // write quotient/remainder, pop one
    logic              set_err;    // record error
    logic [STAT_W-1:0] err_code;
    logic              emit;       // load result register, clear stack
  } pfx_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    cls_t cls;       // class of the symbol on the input port
    logic err_set;   // sticky error present
    logic lt2;       // fewer than two entries
    logic full;      // stack full
    logic b_zero;    // top of stack is zero
    logic op_div;    // latched operator is / or %
    logic div_done;  // divider finished
    logic out_free;  // result register can take a beat
  } pfx_stat_t;

  // Sort a character into its class
  function automatic cls_t classify(input logic [SYM_W-1:0] sym);
    cls_t c;
    case (sym) inside
      CH_NUL:                                     c = CLS_NUL;
      CH_LPAR, CH_RPAR:                           c = CLS_PAREN;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT: c = CLS_OP;
      default:                                    c = CLS_OPND;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/pfx_ram.sv]
// ----------------------------------------------------------------------------
// pfx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/pfx_div.sv]
// ----------------------------------------------------------------------------
// pfx_div
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pfx_div
  import pfx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] dividend,
  input  logic [VAL_W-1:0] divisor,
  output logic [VAL_W-1:0] quot,
  output logic [VAL_W-1:0] rmd,
  output logic             done
);

  localparam int CNT_W = $clog2(DIV_BITS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] quo;
  logic [VAL_W-1:0] den;
  logic             q_neg;
  logic             r_neg;
  logic [VAL_W:0]   rem_sh;
  logic [VAL_W:0]   diff;

  // Trial subtract for the next bit
  assign rem_sh = {rem, quo[VAL_W-1]};
  assign diff   = rem_sh - {1'b0, den};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DIV_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift-subtract datapath on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= '0;
      rem   <= '0;
      quo   <= dividend[VAL_W-1] ? (VAL_W'(0) - dividend) : dividend;
      den   <= divisor[VAL_W-1]  ? (VAL_W'(0) - divisor)  : divisor;
      q_neg <= dividend[VAL_W-1] ^ divisor[VAL_W-1];
      r_neg <= dividend[VAL_W-1];
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (!diff[VAL_W]) begin
        rem <= diff[VAL_W-1:0];
        quo <= {quo[VAL_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[VAL_W-1:0];
        quo <= {quo[VAL_W-2:0], 1'b0};
      end
    end
  end

  // Sign fix-up
  assign quot = q_neg ? (VAL_W'(0) - quo) : quo;
  assign rmd  = r_neg ? (VAL_W'(0) - rem) : rem;

endmodule

[rtl/core/pfx_dpath.sv]
// ----------------------------------------------------------------------------
// pfx_dpath
// Stack datapath: top-of-stack register, stack RAM below it, ALU, divider,
// sticky error and the output result register.
// ----------------------------------------------------------------------------
module pfx_dpath
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = PFX_STACK_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  pfx_cmd_t         cmd,
  output pfx_stat_t        stat,
  input  logic [SYM_W-1:0] s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [SYM_W-1:0]  sym;
  logic [VAL_W-1:0]  tos;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic [STAT_W-1:0] err;
  logic [VAL_W-1:0]  out_value;
  logic [STAT_W-1:0] out_status;
  logic [STAT_W-1:0] emit_status;
  logic [VAL_W-1:0]  ram_rdata;
  logic [VAL_W-1:0]  alu_res;
  logic [VAL_W-1:0]  quot;
  logic [VAL_W-1:0]  rmd;
  logic              div_done;
  logic              op_mod;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);
  assign op_mod = (sym == CH_PCT);

  // Entries below the top of stack; top lives in tos
  pfx_ram #(
    .WIDTH(VAL_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.push && count != '0),
    .waddr(cnt_m1[AW-1:0]),
    .wdata(tos),
    .re   (cmd.rd_second),
    .raddr(cnt_m2[AW-1:0]),
    .rdata(ram_rdata)
  );

  pfx_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(ram_rdata),
    .divisor (tos),
    .quot    (quot),
    .rmd     (rmd),
    .done    (div_done)
  );

  // Add, subtract, multiply (low word); left operand from RAM, right from tos
  always_comb begin
    case (sym)
      CH_PLUS:  alu_res = ram_rdata + tos;
      CH_MINUS: alu_res = ram_rdata - tos;
      default:  alu_res = ram_rdata * tos;
    endcase
  end

  // Status seen by the result beat
  always_comb begin
    if (err != ST_OK) begin
      emit_status = err;
    end else if (count == '0) begin
      emit_status = ST_UNDER;
    end else begin
      emit_status = ST_OK;
    end
  end

  // Stack pointer, top of stack, error
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= ST_OK;
    end else begin
      if (cmd.emit) begin
        count <= '0;
        err   <= ST_OK;
      end else if (cmd.push) begin
        count <= count + CW'(1);
      end else if (cmd.alu_wr || cmd.div_wr) begin
        count <= cnt_m1;
      end
      if (cmd.set_err) begin
        err <= cmd.err_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sym <= s_tdata;
    end
    if (cmd.push) begin
      tos <= {{(VAL_W - SYM_W){1'b0}}, s_tdata} - DIGIT_BASE;
    end else if (cmd.alu_wr) begin
      tos <= alu_res;
    end else if (cmd.div_wr) begin
      tos <= op_mod ? rmd : quot;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= emit_status;
      out_value  <= (emit_status == ST_OK) ? tos : '0;
    end
  end

  assign m_tdata = {{(OUT_W - VAL_W - STAT_W){1'b0}}, out_status, out_value};

  // Status to controller
  assign stat.cls      = classify(s_tdata);
  assign stat.err_set  = (err != ST_OK);
  assign stat.lt2      = (count < CW'(2));
  assign stat.full     = (count >= CW'(STACK_DEPTH));
  assign stat.b_zero   = (tos == '0);
  assign stat.op_div   = (sym == CH_SLASH) || op_mod;
  assign stat.div_done = div_done;
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

[rtl/core/pfx_ctrl.sv]
// ----------------------------------------------------------------------------
// pfx_ctrl
// Controller: decodes each accepted symbol and sequences the datapath.
// ----------------------------------------------------------------------------
module pfx_ctrl
  import pfx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  pfx_stat_t stat,
  output pfx_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OPER,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign s_tready = (state == S_IDLE);
  assign take     = s_tvalid && s_tready;

  // Command decode
  always_comb begin
    cmd        = '0;
    cmd.take   = take;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (stat.cls == CLS_NUL) begin
            state_next = S_EMIT;
          end else if (!stat.err_set) begin
            unique case (stat.cls)
              CLS_PAREN: begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ST_INVALID;
              end
              CLS_OP: begin
                if (stat.lt2) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_UNDER;
                end else begin
                  cmd.rd_second = 1'b1;
                  state_next    = S_OPER;
                end
              end
              default: begin
                if (stat.full) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_OVER;
                end else begin
                  cmd.push = 1'b1;
                end
              end
            endcase
          end
        end
      end
      // Left operand now out of the RAM
      S_OPER: begin
        if (!stat.op_div) begin
          cmd.alu_wr = 1'b1;
          state_next = S_IDLE;
        end else if (stat.b_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DIVZERO;
          state_next   = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_wr = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/postfix_expression_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Postfix (RPN) evaluator over a 32-bit value stack, one character per beat.
// ----------------------------------------------------------------------------
// Each input beat is one character. Operands push (code - 48); + - * / %
// pop two values and push the 32-bit wrapping result; NUL emits one result
// beat (top of stack and status) and empties the stack. The first error of an
// expression sticks until its NUL. Parentheses set an invalid-symbol error and
// every other character is an operand. + - * read the stack RAM, then the ALU;
// a divide by zero is found after the same read; / and % then run the
// one-bit-per-cycle divider. NUL waits while a previous result beat is still
// stalled. A new character is taken only once the last one is done. The top
// of stack is held in a register and the rest of the stack sits in a RAM with
// one write and one read port, so there is no clearing pass after reset.
module postfix_expression_evaluator_unit
  import pfx_pkg::*;
#(
  parameter int STACK_DEPTH = PFX_STACK_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [SYM_W-1:0] s_tdata,   // [7:0] symbol
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // [31:0] value, [34:32] status, [39:35] zero
);

  pfx_cmd_t  cmd;
  pfx_stat_t stat;

  pfx_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  pfx_dpath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

[rtl/core/pfx_chk.sv]
// ----------------------------------------------------------------------------
// pfx_chk
// Port-level checks for the postfix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pfx_chk
  import pfx_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [SYM_W-1:0] s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // Stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("input beat changed while stalled");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Status code stays in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[34:32] <= ST_INVALID)
    else $error("status code out of range");

  // Failed expressions report a zero value
  a_zero_on_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34:32] != ST_OK |-> m_tdata[31:0] == '0)
    else $error("nonzero value with error status");

  // A result beat needs a NUL accepted earlier; never straight out of reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat right after reset");

endmodule

bind postfix_expression_evaluator_unit pfx_chk u_pfx_chk (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
